>>> hdl/gic_pkg.sv
// Shared types and constants for the gamepad input conditioner.
`timescale 1ns / 1ps
package gic_pkg;

  // Widths fixed by the report and result formats.
  localparam int unsigned PAD_W   = 2;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned Q15_W   = 15;
  localparam int unsigned BTN_W   = 10;
  localparam int unsigned HELD9_W = 9;
  localparam int unsigned HELD3_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Iterative unit sizes.
  localparam int unsigned DIV_NW  = 32;
  localparam int unsigned DIV_DW  = 16;
  localparam int unsigned SQRT_IW = 32;
  localparam int unsigned SQRT_OW = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PADS_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_FLR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_THR   = 3'd4;

  // Register reset values.
  localparam logic [Q15_W-1:0] DEAD_ZONE_RST = 15'd6554;
  localparam logic [Q15_W-1:0] MENU_THR_RST  = 15'd18022;
  localparam logic [Q15_W-1:0] TRIG_FLR_RST  = 15'd1966;
  localparam logic [Q15_W-1:0] ACT_THR_RST   = 15'd3277;

  // Squared stick magnitude at or below which the stick counts as centered.
  localparam logic [31:0] MAG_EPS_SQ = 32'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MERGE,
    S_EMIT
  } gic_state_e;

  typedef enum logic [2:0] {
    DIV_SCALE,
    DIV_X,
    DIV_Y,
    DIV_RIGHT,
    DIV_LEFT
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     sum;
    logic     sqrt_start;
    logic     div_start;
    logic     div_store;
    div_sel_e sel;
    logic     merge;
    logic     emit;
  } gic_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic frame_last;
    logic out_free;
  } gic_sts_t;

endpackage

>>> hdl/gic_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gic_div
  import gic_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output logic [DIV_NW-1:0] quotient_o,
  output logic              done_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_NW-1]};
    diff    = shifted - {1'b0, dsr_q};
    fits    = shifted >= {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_NW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> hdl/gic_sqrt.sv
// Integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module gic_sqrt
  import gic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SQRT_IW-1:0] radicand_i,
  output logic [SQRT_OW-1:0] root_o,
  output logic               done_o
);

  localparam int unsigned CNT_W = $clog2(SQRT_OW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SQRT_IW-1:0] rad_q, rad_d;
  logic [SQRT_OW:0]   rem_q, rem_d;
  logic [SQRT_OW-1:0] root_q, root_d;
  logic [SQRT_OW+2:0] trial_rem;
  logic [SQRT_OW+2:0] trial;
  logic [SQRT_OW+2:0] trial_diff;
  logic               fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    trial_rem  = {rem_q, rad_q[SQRT_IW-1 -: 2]};
    trial      = {1'b0, root_q, 2'b01};
    trial_diff = trial_rem - trial;
    fits       = trial_rem >= trial;
    busy_d     = busy_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    rad_d      = rad_q;
    rem_d      = rem_q;
    root_d     = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SQRT_OW - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[SQRT_IW-3:0], 2'b00};
      rem_d  = fits ? trial_diff[SQRT_OW:0] : trial_rem[SQRT_OW:0];
      root_d = {root_q[SQRT_OW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> hdl/gic_ctrl.sv
// Sequencing state machine for the gamepad input conditioner.
`timescale 1ns / 1ps
module gic_ctrl
  import gic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gic_sts_t sts_i,
  output gic_cmd_t cmd_o
);

  gic_state_e state_q, state_d;
  div_sel_e   sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_SCALE;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          sel_d   = DIV_SCALE;
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = S_DIV_GO;
          case (sel_q)
            DIV_SCALE: sel_d = DIV_X;
            DIV_X:     sel_d = DIV_Y;
            DIV_Y:     sel_d = DIV_RIGHT;
            DIV_RIGHT: sel_d = DIV_LEFT;
            default:   state_d = S_MERGE;
          endcase
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = sts_i.frame_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/gic_dp.sv
// Datapath: configuration, conditioning arithmetic, frame merge and result register.
`timescale 1ns / 1ps
module gic_dp
  import gic_pkg::*;
#(
  parameter int unsigned NUM_PADS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gic_cmd_t                    cmd_i,
  output gic_sts_t                    sts_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [Q15_W-1:0]            cfg_data_i,
  input  logic [PAD_W-1:0]            pad_index_i,
  input  logic                        present_i,
  input  logic signed [AXIS_W-1:0]    stick_x_i,
  input  logic signed [AXIS_W-1:0]    stick_y_i,
  input  logic signed [AXIS_W-1:0]    left_trigger_raw_i,
  input  logic signed [AXIS_W-1:0]    right_trigger_raw_i,
  input  logic [BTN_W-1:0]            buttons_i,
  input  logic                        keyboard_active_i,
  input  logic                        frame_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [AXIS_W-1:0]    throttle_o,
  output logic signed [AXIS_W-1:0]    steer_x_o,
  output logic signed [AXIS_W-1:0]    pitch_y_o,
  output logic [HELD3_W-1:0]          held_flags_o,
  output logic [HELD9_W-1:0]          edge_flags_o,
  output logic [PAD_W-1:0]            active_pad_o,
  output logic                        any_available_o,
  output logic                        last_device_pad_o
);

  // Magnitude of a Q1.15 value, 17 bits so that full negative scale fits.
  function automatic logic [AXIS_W:0] abs17(input logic [AXIS_W-1:0] v);
    logic [AXIS_W:0] ext;
    ext = {v[AXIS_W-1], v};
    return v[AXIS_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  // Configuration registers.
  logic             pads_en_q;
  logic [Q15_W-1:0] dz_q, menu_q, floor_q, act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pads_en_q <= 1'b1;
      dz_q      <= DEAD_ZONE_RST;
      menu_q    <= MENU_THR_RST;
      floor_q   <= TRIG_FLR_RST;
      act_q     <= ACT_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PADS_EN:   pads_en_q <= cfg_data_i[0];
        CFG_DEAD_ZONE: dz_q      <= cfg_data_i;
        CFG_MENU_THR:  menu_q    <= cfg_data_i;
        CFG_TRIG_FLR:  floor_q   <= cfg_data_i;
        CFG_ACT_THR:   act_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Learned signed-trigger flags, one per pad.
  logic [NUM_PADS-1:0] lseen_q, rseen_q;
  logic                lseen_cur, rseen_cur;

  always_comb begin
    lseen_cur = 1'b0;
    rseen_cur = 1'b0;
    for (int i = 0; i < NUM_PADS; i++) begin
      if (int'(pad_index_i) == i) begin
        lseen_cur = lseen_q[i];
        rseen_cur = rseen_q[i];
      end
    end
  end

  // Report capture and squared terms.
  logic [PAD_W-1:0]         pad_q;
  logic                     in_range_q, present_q, kb_q, last_q;
  logic signed [AXIS_W-1:0] x_q, y_q, lt_q, rt_q;
  logic [BTN_W-1:0]         btn_q;
  logic                     lsig_q, rsig_q;
  logic [30:0]              pxx_q, pyy_q;
  logic [29:0]              dz2_q;
  logic [31:0]              m2_q;
  logic signed [31:0]       xx, yy;
  logic [29:0]              dzdz;

  assign xx   = stick_x_i * stick_x_i;
  assign yy   = stick_y_i * stick_y_i;
  assign dzdz = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pad_q      <= pad_index_i;
      in_range_q <= int'(pad_index_i) < NUM_PADS;
      present_q  <= present_i;
      kb_q       <= keyboard_active_i;
      last_q     <= frame_last_i;
      x_q        <= stick_x_i;
      y_q        <= stick_y_i;
      lt_q       <= left_trigger_raw_i;
      rt_q       <= right_trigger_raw_i;
      btn_q      <= buttons_i;
      lsig_q     <= lseen_cur | (left_trigger_raw_i <= -16'sd16384);
      rsig_q     <= rseen_cur | (right_trigger_raw_i <= -16'sd16384);
      pxx_q      <= xx[30:0];
      pyy_q      <= yy[30:0];
      dz2_q      <= dzdz;
    end
    if (cmd_i.sum) begin
      m2_q <= {1'b0, pxx_q} + {1'b0, pyy_q};
    end
  end

  // Stick magnitude.
  logic [SQRT_OW-1:0] mag;
  logic               sqrt_done;
  logic               stick_zero;

  gic_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (m2_q),
    .root_o     (mag),
    .done_o     (sqrt_done)
  );

  assign stick_zero = (m2_q <= {2'b00, dz2_q}) || (m2_q <= MAG_EPS_SQ);

  // Divider operand selection.
  logic [AXIS_W-1:0]  scale_q, ax_q, ay_q, tr_r_q, tr_l_q;
  logic [AXIS_W-1:0]  abs_x, abs_y;
  logic [AXIS_W-1:0]  mag_less_dz;
  logic [Q15_W-1:0]   val_r, val_l;
  logic [DIV_DW-1:0]  trig_den;
  logic [DIV_NW-1:0]  num;
  logic [DIV_DW-1:0]  den;
  logic [DIV_NW-1:0]  quo;
  logic               div_done;

  assign abs_x       = AXIS_W'(abs17(x_q));
  assign abs_y       = AXIS_W'(abs17(y_q));
  assign mag_less_dz = mag - {1'b0, dz_q};
  assign val_r = rsig_q ? (Q15_W'({~rt_q[15], rt_q[14:0]} >> 1)) :
                          (rt_q[15] ? '0 : rt_q[14:0]);
  assign val_l = lsig_q ? (Q15_W'({~lt_q[15], lt_q[14:0]} >> 1)) :
                          (lt_q[15] ? '0 : lt_q[14:0]);
  assign trig_den = 16'h8000 - {1'b0, floor_q};

  always_comb begin
    num = '0;
    den = trig_den;
    case (cmd_i.sel)
      DIV_SCALE: begin
        if (mag > {1'b0, dz_q}) num = {1'b0, mag_less_dz, 15'b0};
        den = 16'h8000 - {1'b0, dz_q};
      end
      DIV_X: begin
        num = abs_x * scale_q;
        den = mag;
      end
      DIV_Y: begin
        num = abs_y * scale_q;
        den = mag;
      end
      DIV_RIGHT: begin
        if (val_r > floor_q) num = {2'b00, val_r - floor_q, 15'b0};
      end
      DIV_LEFT: begin
        if (val_l > floor_q) num = {2'b00, val_l - floor_q, 15'b0};
      end
      default: ;
    endcase
  end

  gic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num),
    .divisor_i  (den),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // Capture each quotient; the scale saturates at full deflection.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.sel)
        DIV_SCALE: scale_q <= (quo > 32'h8000) ? 16'h8000 : quo[AXIS_W-1:0];
        DIV_X:     ax_q    <= quo[AXIS_W-1:0];
        DIV_Y:     ay_q    <= quo[AXIS_W-1:0];
        DIV_RIGHT: tr_r_q  <= quo[AXIS_W-1:0];
        DIV_LEFT:  tr_l_q  <= quo[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Conditioned values of this report.
  logic signed [AXIS_W-1:0] sx_c, sy_c, th_c;
  logic signed [AXIS_W:0]   th_wide;
  logic signed [AXIS_W:0]   sx17, sy17, neg_menu, pos_menu;
  logic [HELD9_W-1:0]       now9;
  logic                     active, contrib;

  always_comb begin
    if (stick_zero) begin
      sx_c = '0;
      sy_c = '0;
    end else begin
      sx_c = x_q[15] ? AXIS_W'(-ax_q) : ((ax_q > 16'h7FFF) ? 16'h7FFF : ax_q);
      sy_c = y_q[15] ? AXIS_W'(-ay_q) : ((ay_q > 16'h7FFF) ? 16'h7FFF : ay_q);
    end
    th_wide  = $signed({1'b0, tr_r_q}) - $signed({1'b0, tr_l_q});
    th_c     = th_wide[AXIS_W-1:0];
    sx17     = {sx_c[15], sx_c};
    sy17     = {sy_c[15], sy_c};
    pos_menu = $signed({2'b00, menu_q});
    neg_menu = -pos_menu;
    now9 = {btn_q[1], btn_q[0],
            btn_q[9] | (sx17 > pos_menu),
            btn_q[8] | (sx17 < neg_menu),
            btn_q[7] | (sy17 > pos_menu),
            btn_q[6] | (sy17 < neg_menu),
            btn_q[5], btn_q[4], btn_q[3]};
    active = (abs17(th_c) > {2'b00, act_q}) || (abs17(sx_c) > {2'b00, act_q}) ||
             (abs17(sy_c) > {2'b00, act_q}) || (btn_q != '0);
    contrib = in_range_q & present_q & pads_en_q;
  end

  // Frame accumulator and persistent pad state.
  logic signed [AXIS_W-1:0] acc_th_q, acc_x_q, acc_y_q;
  logic [HELD9_W-1:0]       held9_q, prev_q;
  logic [HELD3_W-1:0]       held3_q;
  logic                     avail_q, ldf_q;
  logic [PAD_W-1:0]         act_pad_q;
  logic                     ldf_now;

  assign ldf_now = ldf_q & ~kb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lseen_q   <= '0;
      rseen_q   <= '0;
      acc_th_q  <= '0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      held9_q   <= '0;
      held3_q   <= '0;
      avail_q   <= 1'b0;
      prev_q    <= '0;
      act_pad_q <= '0;
      ldf_q     <= 1'b0;
    end else if (cmd_i.merge) begin
      if (in_range_q) begin
        for (int i = 0; i < NUM_PADS; i++) begin
          if (int'(pad_q) == i) begin
            if (!present_q) begin
              lseen_q[i] <= 1'b0;
              rseen_q[i] <= 1'b0;
            end else if (pads_en_q) begin
              lseen_q[i] <= lsig_q;
              rseen_q[i] <= rsig_q;
            end
          end
        end
      end
      if (contrib) begin
        avail_q <= 1'b1;
        if (abs17(th_c) > abs17(acc_th_q)) acc_th_q <= th_c;
        if (abs17(sx_c) > abs17(acc_x_q))  acc_x_q  <= sx_c;
        if (abs17(sy_c) > abs17(acc_y_q))  acc_y_q  <= sy_c;
        held3_q <= held3_q | btn_q[HELD3_W-1:0];
        held9_q <= held9_q | now9;
        if (active) begin
          act_pad_q <= pad_q;
          ldf_q     <= 1'b1;
        end
      end
    end else if (cmd_i.emit) begin
      ldf_q    <= ldf_now;
      prev_q   <= held9_q;
      acc_th_q <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      held9_q  <= '0;
      held3_q  <= '0;
      avail_q  <= 1'b0;
    end
  end

  // Result register; it frees when the downstream side takes the request.
  logic ov_q, ov_d;

  always_comb begin
    ov_d = ov_q;
    if (cmd_i.emit) ov_d = 1'b1;
    else if (!out_stall_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else ov_q <= ov_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      throttle_o        <= acc_th_q;
      steer_x_o         <= acc_x_q;
      pitch_y_o         <= acc_y_q;
      held_flags_o      <= held3_q;
      edge_flags_o      <= held9_q & ~prev_q;
      active_pad_o      <= act_pad_q;
      any_available_o   <= avail_q;
      last_device_pad_o <= avail_q & ldf_now;
    end
  end

  assign out_valid_o      = ov_q;
  assign sts_o.sqrt_done  = sqrt_done;
  assign sts_o.div_done   = div_done;
  assign sts_o.frame_last = last_q;
  assign sts_o.out_free   = ~ov_q | ~out_stall_i;

endmodule

>>> hdl/gamepad_input_conditioner_unit.sv
// Top level of the gamepad input conditioner: controller, datapath and checks.
//
//  channel | direction | handshake             | content
//  --------+-----------+-----------------------+------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | one pad report request
//  out     | source    | out_valid_o/out_stall_i | frame result on the last report
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | register index and write data
//
// Each report runs the bit-serial square root, then five passes through the shared
// 32-step divider. One report is worked on at a time. Reset is asynchronous and active
// low and needs no clearing pass. A stalled result sits in the output register while the
// next report is already accepted; a frame end then waits until that register frees.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps
module gamepad_input_conditioner_unit
  import gic_pkg::*;
#(
  parameter int unsigned NUM_PADS = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [PAD_W-1:0]         pad_index_i,
  input  logic                     present_i,
  input  logic signed [AXIS_W-1:0] stick_x_i,
  input  logic signed [AXIS_W-1:0] stick_y_i,
  input  logic signed [AXIS_W-1:0] left_trigger_raw_i,
  input  logic signed [AXIS_W-1:0] right_trigger_raw_i,
  input  logic [BTN_W-1:0]         buttons_i,
  input  logic                     keyboard_active_i,
  input  logic                     frame_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [AXIS_W-1:0] throttle_o,
  output logic signed [AXIS_W-1:0] steer_x_o,
  output logic signed [AXIS_W-1:0] pitch_y_o,
  output logic [HELD3_W-1:0]       held_flags_o,
  output logic [HELD9_W-1:0]       edge_flags_o,
  output logic [PAD_W-1:0]         active_pad_o,
  output logic                     any_available_o,
  output logic                     last_device_pad_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [Q15_W-1:0]         cfg_data_i
);

  gic_cmd_t cmd;
  gic_sts_t sts;

  // Registers accept a write in any cycle.
  assign cfg_ready_o = 1'b1;

  gic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gic_dp #(
    .NUM_PADS (NUM_PADS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .pad_index_i         (pad_index_i),
    .present_i           (present_i),
    .stick_x_i           (stick_x_i),
    .stick_y_i           (stick_y_i),
    .left_trigger_raw_i  (left_trigger_raw_i),
    .right_trigger_raw_i (right_trigger_raw_i),
    .buttons_i           (buttons_i),
    .keyboard_active_i   (keyboard_active_i),
    .frame_last_i        (frame_last_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .throttle_o          (throttle_o),
    .steer_x_o           (steer_x_o),
    .pitch_y_o           (pitch_y_o),
    .held_flags_o        (held_flags_o),
    .edge_flags_o        (edge_flags_o),
    .active_pad_o        (active_pad_o),
    .any_available_o     (any_available_o),
    .last_device_pad_o   (last_device_pad_o)
  );

`ifndef NO_ASSERTIONS
  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.sum, cmd.sqrt_start, cmd.div_start, cmd.div_store,
              cmd.merge, cmd.emit}))
    else $error("more than one controller command in a cycle");

  // An accepted request keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again while a report is in progress");

  // A result is only written into a free output register, and then shows.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result written over a pending result");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("result written but not presented");
`endif

endmodule

>>> test/gic_checker.sv
// Result checker for the gamepad input conditioner: predicts each frame result and compares.
`timescale 1ns / 1ps
module gic_checker
  import gic_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [PAD_W-1:0]         pad_index_i,
  input  logic                     present_i,
  input  logic signed [AXIS_W-1:0] stick_x_i,
  input  logic signed [AXIS_W-1:0] stick_y_i,
  input  logic signed [AXIS_W-1:0] left_trigger_raw_i,
  input  logic signed [AXIS_W-1:0] right_trigger_raw_i,
  input  logic [BTN_W-1:0]         buttons_i,
  input  logic                     keyboard_active_i,
  input  logic                     frame_last_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [AXIS_W-1:0] throttle_i,
  input  logic signed [AXIS_W-1:0] steer_x_i,
  input  logic signed [AXIS_W-1:0] pitch_y_i,
  input  logic [HELD3_W-1:0]       held_flags_i,
  input  logic [HELD9_W-1:0]       edge_flags_i,
  input  logic [PAD_W-1:0]         active_pad_i,
  input  logic                     any_available_i,
  input  logic                     last_device_pad_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [Q15_W-1:0]         cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [15:0] throttle;
    logic signed [15:0] steer_x;
    logic signed [15:0] pitch_y;
    logic [2:0]         held;
    logic [8:0]         edges;
    logic [1:0]         pad;
    logic               avail;
    logic               device;
  } frame_result_t;

  localparam int NPADS = 4;

  // Predictor state.
  logic        pads_en;
  int          dead_zone, menu_thr, trig_floor, act_thr;
  logic [3:0]  left_signed, right_signed;
  logic [8:0]  prev_held;
  int          acc_thr, acc_x, acc_y;
  logic [8:0]  acc_held9;
  logic [2:0]  acc_held3;
  logic        acc_avail;
  logic [1:0]  act_pad;
  logic        pad_last_used;
  frame_result_t frame_results_q[$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = frame_results_q.size();

  function automatic int iabs(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(input longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r = r + 1;
    return r;
  endfunction

  function automatic int scale_axis(input int v, input longint s, input longint m);
    longint q;
    q = longint'(iabs(v)) * s / m;
    if (v < 0) return -int'(q);
    return q > 32767 ? 32767 : int'(q);
  endfunction

  // Remaps one trigger; updates the learned signed flag.
  function automatic int remap_trigger(input int raw, inout logic seen);
    int value;
    if (raw <= -16384) seen = 1'b1;
    value = seen ? ((raw + 32768) >>> 1) : (raw < 0 ? 0 : raw);
    if (value <= trig_floor) return 0;
    return int'(longint'(value - trig_floor) * 32768 / (32768 - trig_floor));
  endfunction

  task automatic predict_report();
    int sx, sy, th, idx;
    longint m2, m, num, s;
    logic [8:0] now;
    logic ls, rs;
    idx = pad_index_i;
    if (idx < NPADS) begin
      if (!present_i) begin
        left_signed[idx]  = 1'b0;
        right_signed[idx] = 1'b0;
      end else if (pads_en) begin
        sx = stick_x_i;
        sy = stick_y_i;
        acc_avail = 1'b1;
        m2 = longint'(sx) * sx + longint'(sy) * sy;
        if (m2 <= longint'(dead_zone) * dead_zone || m2 <= 10) begin
          sx = 0;
          sy = 0;
        end else begin
          m = isqrt(m2);
          num = (m > dead_zone) ? (m - dead_zone) * 32768 / (32768 - dead_zone) : 0;
          s = num > 32768 ? 32768 : num;
          sx = scale_axis(sx, s, m);
          sy = scale_axis(sy, s, m);
        end
        rs = right_signed[idx];
        ls = left_signed[idx];
        th = remap_trigger(int'(right_trigger_raw_i), rs)
           - remap_trigger(int'(left_trigger_raw_i), ls);
        right_signed[idx] = rs;
        left_signed[idx]  = ls;
        if (th > 32767) th = 32767;
        if (th < -32768) th = -32768;
        if (iabs(th) > iabs(acc_thr)) acc_thr = th;
        if (iabs(sx) > iabs(acc_x)) acc_x = sx;
        if (iabs(sy) > iabs(acc_y)) acc_y = sy;
        acc_held3 |= buttons_i[2:0];
        now = '0;
        now[0] = buttons_i[3];
        now[1] = buttons_i[4];
        now[2] = buttons_i[5];
        now[3] = buttons_i[6] || sy < -menu_thr;
        now[4] = buttons_i[7] || sy > menu_thr;
        now[5] = buttons_i[8] || sx < -menu_thr;
        now[6] = buttons_i[9] || sx > menu_thr;
        now[7] = buttons_i[0];
        now[8] = buttons_i[1];
        acc_held9 |= now;
        if (iabs(th) > act_thr || iabs(sx) > act_thr || iabs(sy) > act_thr ||
            buttons_i != '0) begin
          act_pad = idx[1:0];
          pad_last_used = 1'b1;
        end
      end
    end
    // The frame's last report closes the frame and yields one result.
    if (frame_last_i) begin
      frame_result_t r;
      if (keyboard_active_i) pad_last_used = 1'b0;
      r.throttle = acc_thr[15:0];
      r.steer_x  = acc_x[15:0];
      r.pitch_y  = acc_y[15:0];
      r.held     = acc_held3;
      r.edges    = acc_held9 & ~prev_held;
      r.pad      = act_pad;
      r.avail    = acc_avail;
      r.device   = acc_avail && pad_last_used;
      frame_results_q.push_back(r);
      prev_held = acc_held9;
      acc_thr = 0; acc_x = 0; acc_y = 0;
      acc_held9 = '0; acc_held3 = '0; acc_avail = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pads_en = 1'b1;
      dead_zone = 6554; menu_thr = 18022; trig_floor = 1966; act_thr = 3277;
      left_signed = '0; right_signed = '0; prev_held = '0;
      acc_thr = 0; acc_x = 0; acc_y = 0;
      acc_held9 = '0; acc_held3 = '0; acc_avail = 1'b0;
      act_pad = '0; pad_last_used = 1'b0;
      mismatches = 0;
    end else begin
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PADS_EN:   pads_en = cfg_data_i[0];
          CFG_DEAD_ZONE: dead_zone = cfg_data_i;
          CFG_MENU_THR:  menu_thr = cfg_data_i;
          CFG_TRIG_FLR:  trig_floor = cfg_data_i;
          CFG_ACT_THR:   act_thr = cfg_data_i;
          default: ;
        endcase
      end
      // Compare each delivered result with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        frame_result_t got, want;
        got = '{throttle_i, steer_x_i, pitch_y_i, held_flags_i, edge_flags_i,
                active_pad_i, any_available_i, last_device_pad_i};
        if (frame_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", got);
        end else begin
          want = frame_results_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp thr=%0d x=%0d y=%0d held=%h edge=%h pad=%0d av=%b dev=%b | got thr=%0d x=%0d y=%0d held=%h edge=%h pad=%0d av=%b dev=%b",
                want.throttle, want.steer_x, want.pitch_y, want.held, want.edges,
                want.pad, want.avail, want.device, got.throttle, got.steer_x,
                got.pitch_y, got.held, got.edges, got.pad, got.avail, got.device);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_report();
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for the gamepad input conditioner: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb;
  import gic_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PAD_W-1:0] pad_index_i = '0;
  logic present_i = 1'b0;
  logic signed [AXIS_W-1:0] stick_x_i = '0, stick_y_i = '0;
  logic signed [AXIS_W-1:0] left_trigger_raw_i = '0, right_trigger_raw_i = '0;
  logic [BTN_W-1:0] buttons_i = '0;
  logic keyboard_active_i = 1'b0, frame_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [AXIS_W-1:0] throttle_o, steer_x_o, pitch_y_o;
  logic [HELD3_W-1:0] held_flags_o;
  logic [HELD9_W-1:0] edge_flags_o;
  logic [PAD_W-1:0] active_pad_o;
  logic any_available_o, last_device_pad_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [Q15_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  logic calm;  // no idling on either side while set

  always #10 clk_i = ~clk_i;

  gamepad_input_conditioner_unit u_dut (.*);

  gic_checker u_chk (
    .in_stall_i(in_stall_o), .out_valid_i(out_valid_o), .throttle_i(throttle_o),
    .steer_x_i(steer_x_o), .pitch_y_i(pitch_y_o), .held_flags_i(held_flags_o),
    .edge_flags_i(edge_flags_o), .active_pad_i(active_pad_o),
    .any_available_i(any_available_o), .last_device_pad_i(last_device_pad_o),
    .cfg_ready_i(cfg_ready_o), .fail_count_o(fail_count), .pending_o(pending), .*);

  // Receiver stalls at random, except in the calm stretch.
  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 23);

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[Q15_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every predicted frame has arrived, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Valid stays high after an accept until the next request or an idle cycle.
  task automatic send_report(input logic [1:0] pad, input logic pres,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] lt, input logic [15:0] rt,
                             input logic [9:0] btn, input logic kb, input logic last);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pad_index_i <= pad; present_i <= pres; stick_x_i <= x; stick_y_i <= y;
    left_trigger_raw_i <= lt; right_trigger_raw_i <= rt; buttons_i <= btn;
    keyboard_active_i <= kb; frame_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_reports(input int n);
    logic [1:0] pad;
    for (int i = 0; i < n; i++) begin
      pad = $urandom_range(3);
      send_report(pad, $urandom_range(99) < 90, rand_axis(), rand_axis(),
                  rand_axis(), rand_axis(),
                  ($urandom_range(3) == 0) ? 10'($urandom) : 10'd0,
                  $urandom_range(3) == 0, $urandom_range(2) == 0);
    end
    send_report(2'd0, 1'b1, '0, '0, '0, '0, '0, 1'b0, 1'b1);
  endtask

  initial begin
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, signed trigger learning, absent pad, ties, keyboard.
    send_report(2'd0, 1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 10'h3ff, 1'b0, 1'b1);
    send_report(2'd1, 1'b1, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 10'h000, 1'b0, 1'b0);
    send_report(2'd2, 1'b1, 16'h8000, 16'h8000, 16'h0000, 16'hc000, 10'h000, 1'b0, 1'b1);
    send_report(2'd3, 1'b1, 16'd3, 16'd1, 16'd100, 16'd1966, 10'h001, 1'b1, 1'b1);
    send_report(2'd0, 1'b0, 16'h7fff, 16'h0, 16'h8000, 16'h8000, 10'h3ff, 1'b0, 1'b1);
    send_report(2'd1, 1'b1, 16'd0, 16'd6554, 16'd0, 16'd0, 10'h0, 1'b0, 1'b0);
    send_report(2'd2, 1'b1, 16'd0, -16'sd6555, 16'd0, 16'd0, 10'h0, 1'b0, 1'b1);
    send_report(2'd1, 1'b1, 16'd20000, 16'd0, 16'd0, 16'd0, 10'h0, 1'b0, 1'b0);
    send_report(2'd2, 1'b1, -16'sd20000, 16'd0, 16'd0, 16'd0, 10'h0, 1'b1, 1'b1);
    send_report(2'd3, 1'b1, 16'd0, 16'd0, 16'h8000, 16'h7fff, 10'h2aa, 1'b0, 1'b1);
    send_report(2'd3, 1'b1, 16'd0, 16'd0, 16'h0, 16'h0, 10'h155, 1'b0, 1'b1);
    drain();

    // Phases through several register settings, extremes included.
    calm = 1'b1;
    write_reg(CFG_DEAD_ZONE, 0);
    write_reg(CFG_MENU_THR, 0);
    write_reg(CFG_TRIG_FLR, 0);
    write_reg(CFG_ACT_THR, 0);
    random_reports(250);
    drain();
    calm = 1'b0;
    write_reg(CFG_DEAD_ZONE, 32767);
    write_reg(CFG_MENU_THR, 32767);
    write_reg(CFG_TRIG_FLR, 32767);
    write_reg(CFG_ACT_THR, 32767);
    random_reports(200);
    drain();
    write_reg(CFG_PADS_EN, 0);
    random_reports(100);
    drain();
    write_reg(CFG_PADS_EN, 1);
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_DEAD_ZONE, $urandom_range(12000));
      write_reg(CFG_MENU_THR, $urandom_range(32767));
      write_reg(CFG_TRIG_FLR, $urandom_range(8000));
      write_reg(CFG_ACT_THR, $urandom_range(32767));
      random_reports(200);
      drain();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
